// File: rtl/rls_friction_estimator_macros.svh
// assertion helpers shared by the friction estimator modules
`ifndef RLS_FRICTION_ESTIMATOR_MACROS_SVH
`define RLS_FRICTION_ESTIMATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rls assertion failed");

// next-cycle implication, disabled while in reset
`define RLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rls assertion failed");

`endif

// File: rtl/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// types and constants shared by the friction estimator and its muldiv unit
// ----------------------------------------------------------------------------
package rls_pkg;

    typedef enum logic [1:0] {
        MD_SH11,
        MD_SH13,
        MD_SH32,
        MD_DIV
    } md_mode_t;

    // request to the shared multiply/round/divide unit
    typedef struct packed {
        logic               start;
        md_mode_t           mode;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [63:0]        d;
    } md_req_t;

    localparam logic signed [63:0] LIM62   = 64'sh4000_0000_0000_0000;
    localparam logic [63:0]        EPS_Q32 = 64'd4295;
    localparam logic [13:0]        MU_MIN  = 14'd819;
    localparam logic [13:0]        MU_MAX  = 14'd12288;

    localparam logic [1:0] CFG_SLIP_THR = 2'd0;
    localparam logic [1:0] CFG_LAMBDA   = 2'd1;
    localparam logic [1:0] CFG_FR_INIT  = 2'd2;

endpackage

// File: rtl/rls_mdu.sv
// ----------------------------------------------------------------------------
// rls_mdu
// round(a*b/d) with halves away from zero, magnitude saturated to 2^62;
// four 32x32 partial products, then shift or restoring divide
// ----------------------------------------------------------------------------
`include "rls_friction_estimator_macros.svh"

module rls_mdu
(
    input  logic                clk,
    input  logic                rst_n,
    input  rls_pkg::md_req_t    req,
    output logic                done,
    output logic signed [63:0]  result
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_RND,
        M_DIV,
        M_FIN
    } mstate_t;

    mstate_t           state_reg;
    logic [63:0]       ua_reg;
    logic [63:0]       ub_reg;
    logic              neg_reg;
    rls_pkg::md_mode_t mode_reg;
    logic [63:0]       d_reg;
    logic [127:0]      acc_reg;
    logic [6:0]        cnt_reg;
    logic [64:0]       rem_reg;
    logic [63:0]       q_reg;
    logic              ovf_reg;
    logic              done_reg;
    logic signed [63:0] result_reg;

    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] acc_rnd;
    logic [127:0] shifted;
    logic [64:0]  rem_sh;
    logic         ge;
    logic [63:0]  mag;

    always_comb
    begin
        pa = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        pb = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp = pa * pb;
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        acc_rnd = acc_reg + {65'd0, d_reg[63:1]};
        case (mode_reg)
            rls_pkg::MD_SH11: shifted = acc_rnd >> 11;
            rls_pkg::MD_SH13: shifted = acc_rnd >> 13;
            default:          shifted = acc_rnd >> 32;
        endcase
        rem_sh = {rem_reg[63:0], acc_reg[127]};
        ge     = (rem_sh >= {1'b0, d_reg});
        mag    = (ovf_reg || (q_reg > 64'(rls_pkg::LIM62))) ? 64'(rls_pkg::LIM62) : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        ua_reg   <= req.a[63] ? 64'(-req.a) : 64'(req.a);
                        ub_reg   <= req.b[63] ? 64'(-req.b) : 64'(req.b);
                        neg_reg  <= req.a[63] ^ req.b[63];
                        mode_reg <= req.mode;
                        case (req.mode)
                            rls_pkg::MD_SH11: d_reg <= 64'd1 << 11;
                            rls_pkg::MD_SH13: d_reg <= 64'd1 << 13;
                            rls_pkg::MD_SH32: d_reg <= 64'd1 << 32;
                            default:          d_reg <= req.d;
                        endcase
                        acc_reg   <= 128'd0;
                        cnt_reg   <= 7'd0;
                        state_reg <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    acc_reg <= acc_reg + pp_sh;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        state_reg <= M_RND;
                    end
                end
                M_RND:
                begin
                    acc_reg <= acc_rnd;
                    cnt_reg <= 7'd0;
                    rem_reg <= 65'd0;
                    if (mode_reg == rls_pkg::MD_DIV)
                    begin
                        q_reg     <= 64'd0;
                        ovf_reg   <= 1'b0;
                        state_reg <= M_DIV;
                    end
                    else
                    begin
                        q_reg     <= shifted[63:0];
                        ovf_reg   <= |shifted[127:63];
                        state_reg <= M_FIN;
                    end
                end
                M_DIV:
                begin
                    acc_reg <= {acc_reg[126:0], 1'b0};
                    rem_reg <= ge ? (rem_sh - {1'b0, d_reg}) : rem_sh;
                    if (q_reg[63:62] != 2'b00)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    q_reg   <= {q_reg[62:0], ge};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127)
                    begin
                        state_reg <= M_FIN;
                    end
                end
                M_FIN:
                begin
                    result_reg <= neg_reg ? -$signed(mag) : $signed(mag);
                    done_reg   <= 1'b1;
                    state_reg  <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `RLS_ASSERT_IMP(a_start_idle, clk, rst_n, req.start, state_reg == M_IDLE)
    `RLS_ASSERT_NXT(a_start_runs, clk, rst_n, req.start, state_reg == M_MUL)
    `RLS_ASSERT_IMP(a_result_sat, clk, rst_n, done_reg,
        (result_reg <= rls_pkg::LIM62) && (result_reg >= -rls_pkg::LIM62))

endmodule

// File: rtl/rls_friction_estimator.sv
// ----------------------------------------------------------------------------
// rls_friction_estimator
// two-parameter recursive least squares friction fit with forgetting factor
// ----------------------------------------------------------------------------
// s_axis carries one sample per transaction: slip and traction force, both
// signed Q2.13. m_axis returns one result per sample: the clamped friction
// coefficient and the fit confidence on tdata, the applied flag on tuser.
// a sample below the slip threshold is answered in the cycle after it is taken
// with the held values. an applied sample runs 27 operations through one
// shared muldiv unit: each passes through the partial-product multiply, a
// rounding step and a handoff, and the seven true divisions (gains,
// covariance scaling, confidence) also go through the bit-serial divider.
// when the denominator is too small for a gain update, the gain, theta and
// covariance steps are skipped. the next sample is taken only once the
// result of the last one has been taken off m_axis.
// s_axis_tready is high only while no sample is in work and no result waits.
// a result stays on m_axis until it is taken; a stalled receiver holds off
// the next sample.
// reset loads the register defaults, theta to the initial friction and zero,
// the covariance to 100 times identity and clears the held confidence.
// cfg_we writes a register at once; the initial friction write reloads theta.
// ----------------------------------------------------------------------------
`include "rls_friction_estimator_macros.svh"

module rls_friction_estimator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // slip_ratio[15:0], traction_force[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // friction_estimate[13:0], fit_confidence[29:14],
                                        // zero[31:30]
    output logic        m_axis_tuser,   // was_applied[0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_START,
        T_WAIT,
        T_OUT
    } tstate_t;

    typedef enum logic [4:0] {
        ST_PHI1, ST_YH0, ST_YH1, ST_PP00, ST_PP01, ST_PP10, ST_PP11,
        ST_RV00, ST_RV01, ST_RV10, ST_RV11, ST_Q0, ST_Q1, ST_K0, ST_K1,
        ST_TH0, ST_TH1, ST_D00, ST_P00, ST_D01, ST_P01, ST_D10, ST_P10,
        ST_D11, ST_P11, ST_FR, ST_CONF
    } step_t;

    tstate_t state_reg;
    step_t   step_reg;
    step_t   step_next;

    logic [14:0] thr_reg;
    logic [15:0] lam_reg;

    logic signed [31:0] th_reg [2];
    logic signed [47:0] p_reg  [4];
    logic [13:0]        fhold_reg;
    logic [15:0]        chold_reg;

    logic signed [15:0] s_reg;
    logic signed [15:0] f_reg;
    logic signed [63:0] phi1_reg;
    logic signed [63:0] yhat_reg;
    logic signed [63:0] err_reg;
    logic signed [63:0] pphi_reg [2];
    logic signed [63:0] rowv_reg [2];
    logic signed [63:0] quad_reg;
    logic signed [63:0] k_reg [2];
    logic signed [63:0] diff_reg;
    logic [63:0]        aden_reg;
    logic               dneg_reg;

    logic [13:0] out_fr_reg;
    logic [15:0] out_conf_reg;
    logic        out_app_reg;

    rls_pkg::md_req_t   md_req;
    logic               md_done;
    logic signed [63:0] md_res;

    logic signed [63:0] phi0;
    logic signed [63:0] denom_c;
    logic [63:0]        aden_c;
    logic signed [63:0] err_c;
    logic [63:0]        aerr;
    logic [63:0]        lam_c;
    logic [16:0]        slip_mag;
    logic               in_acc;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh0000_7FFF_FFFF_FFFF)
            return 48'sh7FFF_FFFF_FFFF;
        else if (v < -64'sh0000_8000_0000_0000)
            return 48'sh8000_0000_0000;
        else
            return v[47:0];
    endfunction

    function automatic logic [13:0] clamp_mu(input logic signed [63:0] v);
        if (v < $signed({50'd0, rls_pkg::MU_MIN}))
            return rls_pkg::MU_MIN;
        else if (v > $signed({50'd0, rls_pkg::MU_MAX}))
            return rls_pkg::MU_MAX;
        else
            return v[13:0];
    endfunction

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign phi0     = 64'(s_reg);
    assign slip_mag = s_axis_tdata[15] ? (17'd0 - {1'b1, s_axis_tdata[15:0]})
                                       : {1'b0, s_axis_tdata[15:0]};
    assign lam_c    = (lam_reg == 16'd0) ? 64'd1 : {48'd0, lam_reg};
    assign aerr     = err_reg[63] ? 64'(-err_reg) : 64'(err_reg);
    assign err_c    = ($signed(64'(f_reg)) <<< 11) - (yhat_reg + md_res);
    assign denom_c  = $signed({31'd0, lam_reg, 17'd0}) + quad_reg + md_res;
    assign aden_c   = denom_c[63] ? 64'(-denom_c) : 64'(denom_c);

    // operand selection for the shared unit
    always_comb
    begin
        md_req.start = (state_reg == T_START);
        md_req.mode  = rls_pkg::MD_SH13;
        md_req.a     = phi0;
        md_req.b     = phi0;
        md_req.d     = 64'd0;
        case (step_reg)
            ST_PHI1:
            begin
                md_req.a = phi0;
                md_req.b = phi0;
            end
            ST_YH0:
            begin
                md_req.a = 64'(th_reg[0]);
                md_req.b = phi0;
            end
            ST_YH1:
            begin
                md_req.a = 64'(th_reg[1]);
                md_req.b = phi1_reg;
            end
            ST_PP00:
            begin
                md_req.a = 64'(p_reg[0]);
                md_req.b = phi0;
            end
            ST_PP01:
            begin
                md_req.a = 64'(p_reg[1]);
                md_req.b = phi1_reg;
            end
            ST_PP10:
            begin
                md_req.a = 64'(p_reg[2]);
                md_req.b = phi0;
            end
            ST_PP11:
            begin
                md_req.a = 64'(p_reg[3]);
                md_req.b = phi1_reg;
            end
            ST_RV00:
            begin
                md_req.a = phi0;
                md_req.b = 64'(p_reg[0]);
            end
            ST_RV01:
            begin
                md_req.a = phi1_reg;
                md_req.b = 64'(p_reg[2]);
            end
            ST_RV10:
            begin
                md_req.a = phi0;
                md_req.b = 64'(p_reg[1]);
            end
            ST_RV11:
            begin
                md_req.a = phi1_reg;
                md_req.b = 64'(p_reg[3]);
            end
            ST_Q0:
            begin
                md_req.a = phi0;
                md_req.b = pphi_reg[0];
            end
            ST_Q1:
            begin
                md_req.a = phi1_reg;
                md_req.b = pphi_reg[1];
            end
            ST_K0, ST_K1:
            begin
                md_req.mode = rls_pkg::MD_DIV;
                md_req.a    = (step_reg == ST_K0) ? pphi_reg[0] : pphi_reg[1];
                md_req.b    = 64'sd1 <<< 32;
                md_req.d    = aden_reg;
            end
            ST_TH0, ST_TH1:
            begin
                md_req.mode = rls_pkg::MD_SH32;
                md_req.a    = (step_reg == ST_TH0) ? k_reg[0] : k_reg[1];
                md_req.b    = err_reg;
            end
            ST_D00:
            begin
                md_req.mode = rls_pkg::MD_SH32;
                md_req.a    = k_reg[0];
                md_req.b    = rowv_reg[0];
            end
            ST_D01:
            begin
                md_req.mode = rls_pkg::MD_SH32;
                md_req.a    = k_reg[0];
                md_req.b    = rowv_reg[1];
            end
            ST_D10:
            begin
                md_req.mode = rls_pkg::MD_SH32;
                md_req.a    = k_reg[1];
                md_req.b    = rowv_reg[0];
            end
            ST_D11:
            begin
                md_req.mode = rls_pkg::MD_SH32;
                md_req.a    = k_reg[1];
                md_req.b    = rowv_reg[1];
            end
            ST_P00, ST_P01, ST_P10, ST_P11:
            begin
                md_req.mode = rls_pkg::MD_DIV;
                md_req.a    = diff_reg;
                md_req.b    = 64'sd1 <<< 15;
                md_req.d    = lam_c;
            end
            ST_FR:
            begin
                md_req.mode = rls_pkg::MD_SH11;
                md_req.a    = 64'(th_reg[0]);
                md_req.b    = 64'sd1;
            end
            ST_CONF:
            begin
                md_req.mode = rls_pkg::MD_DIV;
                md_req.a    = 64'sd1 <<< 15;
                md_req.b    = 64'sd1 <<< 24;
                md_req.d    = (64'd1 << 24) + aerr;
            end
            default: md_req.mode = rls_pkg::MD_SH13;
        endcase
    end

    // sequencer step after the current operation completes
    always_comb
    begin
        step_next = step_t'(step_reg + 5'd1);
        case (step_reg)
            ST_Q1:
            begin
                // tiny denominator leaves theta and P alone
                if (aden_c <= rls_pkg::EPS_Q32)
                begin
                    step_next = ST_FR;
                end
            end
            ST_CONF: step_next = ST_PHI1;
            default: ;
        endcase
    end

    rls_mdu u_mdu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .done   (md_done),
        .result (md_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            step_reg    <= ST_PHI1;
            thr_reg     <= 15'd410;
            lam_reg     <= 16'd32440;
            th_reg[0]   <= 32'sd6554 <<< 11;
            th_reg[1]   <= 32'sd0;
            p_reg[0]    <= 48'sd100 <<< 32;
            p_reg[1]    <= 48'sd0;
            p_reg[2]    <= 48'sd0;
            p_reg[3]    <= 48'sd100 <<< 32;
            fhold_reg   <= 14'd6554;
            chold_reg   <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rls_pkg::CFG_SLIP_THR: thr_reg <= cfg_data[14:0];
                    rls_pkg::CFG_LAMBDA:   lam_reg <= cfg_data;
                    rls_pkg::CFG_FR_INIT:
                    begin
                        th_reg[0] <= $signed({7'd0, cfg_data[13:0], 11'd0});
                        th_reg[1] <= 32'sd0;
                        fhold_reg <= clamp_mu(64'({50'd0, cfg_data[13:0]}));
                    end
                    default: ;
                endcase
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (in_acc)
                    begin
                        s_reg    <= s_axis_tdata[15:0];
                        f_reg    <= s_axis_tdata[31:16];
                        step_reg <= ST_PHI1;
                        if (slip_mag < {2'd0, thr_reg})
                        begin
                            out_fr_reg   <= fhold_reg;
                            out_conf_reg <= chold_reg;
                            out_app_reg  <= 1'b0;
                            state_reg    <= T_OUT;
                        end
                        else
                        begin
                            state_reg <= T_START;
                        end
                    end
                end
                T_START:
                begin
                    state_reg <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (md_done)
                    begin
                        state_reg <= (step_reg == ST_CONF) ? T_OUT : T_START;
                        step_reg  <= step_next;
                        case (step_reg)
                            ST_PHI1: phi1_reg <= md_res;
                            ST_YH0:  yhat_reg <= md_res;
                            ST_YH1:  err_reg  <= err_c;
                            ST_PP00: pphi_reg[0] <= md_res;
                            ST_PP01: pphi_reg[0] <= pphi_reg[0] + md_res;
                            ST_PP10: pphi_reg[1] <= md_res;
                            ST_PP11: pphi_reg[1] <= pphi_reg[1] + md_res;
                            ST_RV00: rowv_reg[0] <= md_res;
                            ST_RV01: rowv_reg[0] <= rowv_reg[0] + md_res;
                            ST_RV10: rowv_reg[1] <= md_res;
                            ST_RV11: rowv_reg[1] <= rowv_reg[1] + md_res;
                            ST_Q0:   quad_reg <= md_res;
                            ST_Q1:
                            begin
                                aden_reg <= aden_c;
                                dneg_reg <= denom_c[63];
                            end
                            ST_K0:   k_reg[0] <= dneg_reg ? -md_res : md_res;
                            ST_K1:   k_reg[1] <= dneg_reg ? -md_res : md_res;
                            ST_TH0:  th_reg[0] <= sat32(64'(th_reg[0]) + md_res);
                            ST_TH1:  th_reg[1] <= sat32(64'(th_reg[1]) + md_res);
                            ST_D00:  diff_reg <= 64'(p_reg[0]) - md_res;
                            ST_P00:  p_reg[0] <= sat48(md_res);
                            ST_D01:  diff_reg <= 64'(p_reg[1]) - md_res;
                            ST_P01:  p_reg[1] <= sat48(md_res);
                            ST_D10:  diff_reg <= 64'(p_reg[2]) - md_res;
                            ST_P10:  p_reg[2] <= sat48(md_res);
                            ST_D11:  diff_reg <= 64'(p_reg[3]) - md_res;
                            ST_P11:  p_reg[3] <= sat48(md_res);
                            ST_FR:   fhold_reg <= clamp_mu(md_res);
                            ST_CONF:
                            begin
                                chold_reg    <= md_res[15:0];
                                out_fr_reg   <= fhold_reg;
                                out_conf_reg <= md_res[15:0];
                                out_app_reg  <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                T_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == T_IDLE);
    assign m_axis_tvalid = (state_reg == T_OUT);
    assign m_axis_tdata  = {2'b00, out_conf_reg, out_fr_reg};
    assign m_axis_tuser  = out_app_reg;

    `RLS_ASSERT_IMP(a_ready_no_result, clk, rst_n, s_axis_tready, !m_axis_tvalid)
    `RLS_ASSERT_IMP(a_done_in_wait, clk, rst_n, md_done, state_reg == T_WAIT)
    `RLS_ASSERT_NXT(a_skip_fast, clk, rst_n,
        in_acc && (slip_mag < {2'd0, thr_reg}), m_axis_tvalid && !m_axis_tuser)

endmodule

// File: tb/rls_friction_estimator_test.sv
// ----------------------------------------------------------------------------
// rls_friction_estimator_test
// self-checking bench for the recursive least squares friction estimator
// ----------------------------------------------------------------------------
// samples go in on s_axis and results come back on m_axis. A scoreboard class
// keeps its own copy of theta, the covariance and the held outputs, predicts
// each result in fixed point and compares it field by field. Registers are
// rewritten between phases while nothing is in flight. Both sides idle at
// random, and the receiver also holds off for one long stretch.
// ----------------------------------------------------------------------------
module rls_friction_estimator_test;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam longint     SAT62     = 64'sh4000_0000_0000_0000;

    typedef struct packed {
        logic        applied;
        logic [1:0]  spare;
        logic [15:0] confidence;
        logic [13:0] friction;
    } friction_result_t;

    class friction_scoreboard;
        logic [14:0]        slip_thr;
        logic [15:0]        lambda;
        logic [13:0]        mu_init;
        longint             theta [2];
        longint             cov [4];
        logic [13:0]        mu_hold;
        logic [15:0]        conf_hold;
        friction_result_t   pending [$];

        function new();
            slip_thr  = 15'd410;
            lambda    = 16'd32440;
            mu_init   = 14'd6554;
            cov[0]    = longint'(100) <<< 32;
            cov[1]    = 0;
            cov[2]    = 0;
            cov[3]    = longint'(100) <<< 32;
            conf_hold = '0;
            reload_mu();
        endfunction

        // round(a*b/d), halves away from zero, magnitude capped at 2^62
        function longint rmuldiv(longint a, longint b, longint unsigned d);
            logic [127:0]        prod;
            logic [127:0]        quo;
            longint unsigned     ua;
            longint unsigned     ub;
            bit                  neg;
            neg = (a < 0) != (b < 0);
            ua = (a < 0) ? 64'd0 - longint'(a) : a;
            ub = (b < 0) ? 64'd0 - longint'(b) : b;
            if (d == 0)
                return neg ? -SAT62 : SAT62;
            prod = {64'd0, ua} * {64'd0, ub};
            prod = prod + {64'd0, d >> 1};
            quo = prod / {64'd0, d};
            if (quo > 128'(SAT62))
                quo = 128'(SAT62);
            return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        endfunction

        function logic [13:0] clamp_mu(longint v);
            if (v < longint'(rls_pkg::MU_MIN))
                return rls_pkg::MU_MIN;
            if (v > longint'(rls_pkg::MU_MAX))
                return rls_pkg::MU_MAX;
            return v[13:0];
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void reload_mu();
            theta[0] = longint'(mu_init) <<< 11;
            theta[1] = 0;
            mu_hold  = clamp_mu(longint'(mu_init));
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                rls_pkg::CFG_SLIP_THR: slip_thr = val[14:0];
                rls_pkg::CFG_LAMBDA:   lambda = val;
                rls_pkg::CFG_FR_INIT:
                begin
                    mu_init = val[13:0];
                    reload_mu();
                end
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [15:0] slip, logic signed [15:0] force_in);
            friction_result_t r;
            longint s, f, mag, phi0, phi1, yhat, err, quad, denom, adenom, lam, aerr;
            longint pphi [2];
            longint rowv [2];
            longint gain [2];
            longint diff, np;
            s = slip;
            f = force_in;
            mag = s < 0 ? -s : s;
            r.spare = 2'b00;
            if (mag < longint'(slip_thr))
            begin
                r.applied = 1'b0;
            end
            else
            begin
                phi0 = s;
                phi1 = rmuldiv(s, s, 8192);
                yhat = rmuldiv(theta[0], phi0, 8192) + rmuldiv(theta[1], phi1, 8192);
                err  = f * 2048 - yhat;
                for (int i = 0; i < 2; i++)
                begin
                    pphi[i] = rmuldiv(cov[2*i], phi0, 8192) + rmuldiv(cov[2*i+1], phi1, 8192);
                    rowv[i] = rmuldiv(phi0, cov[i], 8192) + rmuldiv(phi1, cov[2+i], 8192);
                end
                quad   = rmuldiv(phi0, pphi[0], 8192) + rmuldiv(phi1, pphi[1], 8192);
                denom  = (longint'(lambda) <<< 17) + quad;
                adenom = denom < 0 ? -denom : denom;
                // gain update only when the denominator is clear of zero
                if (adenom > longint'(rls_pkg::EPS_Q32))
                begin
                    lam = (lambda == 0) ? 1 : longint'(lambda);
                    for (int i = 0; i < 2; i++)
                    begin
                        gain[i] = rmuldiv(pphi[i], longint'(1) <<< 32, adenom);
                        if (denom < 0)
                            gain[i] = -gain[i];
                    end
                    for (int i = 0; i < 2; i++)
                        theta[i] = sat(theta[i] + rmuldiv(gain[i], err, 64'd1 << 32),
                                       -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1);
                    for (int i = 0; i < 2; i++)
                    begin
                        for (int j = 0; j < 2; j++)
                        begin
                            diff = cov[2*i+j] - rmuldiv(gain[i], rowv[j], 64'd1 << 32);
                            np = rmuldiv(diff, longint'(1) <<< 15, lam);
                            cov[2*i+j] = sat(np, -(longint'(1) <<< 47),
                                             (longint'(1) <<< 47) - 1);
                        end
                    end
                end
                mu_hold = clamp_mu(rmuldiv(theta[0], 1, 2048));
                aerr = err < 0 ? -err : err;
                np = rmuldiv(longint'(1) <<< 15, longint'(1) <<< 24,
                             (longint'(1) <<< 24) + aerr);
                conf_hold = np[15:0];
                r.applied = 1'b1;
            end
            r.friction   = mu_hold;
            r.confidence = conf_hold;
            pending.push_back(r);
        endfunction

        // returns 1 when the result matches the oldest prediction
        function bit check_result(friction_result_t got, output string msg);
            friction_result_t want;
            if (pending.size() == 0)
            begin
                msg = $sformatf("unexpected result %h", got);
                return 0;
            end
            want = pending.pop_front();
            msg = $sformatf("got mu=%0d conf=%0d applied=%0d spare=%0d, want %0d %0d %0d 0",
                            got.friction, got.confidence, got.applied, got.spare,
                            want.friction, want.confidence, want.applied);
            return got == want;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    friction_scoreboard sb;
    int errors;
    int snd_idle;
    int rcv_idle;
    bit hold_req;
    int hold_left;

    rls_friction_estimator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // receiver side, with its own counter for the long hold-off
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
            hold_left <= 3000;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        if (hold_left > 1 || (hold_req && hold_left == 0))
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (!sb.check_result(friction_result_t'({m_axis_tuser, m_axis_tdata}), msg))
                report_mismatch(msg);
        end
    end

    task automatic send_sample(logic [15:0] slip, logic [15:0] force_in);
        while ($urandom_range(99) < snd_idle)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {force_in, slip};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_sample(slip, force_in);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic random_sample();
        logic [15:0] s;
        logic [15:0] f;
        int pick;
        pick = $urandom_range(9);
        f = 16'($urandom());
        if (pick < 5)
            s = 16'($signed($urandom_range(6000)) - 3000);
        else if (pick < 7)
            s = 16'($signed(32'(sb.slip_thr)) * ($urandom_range(1) ? 1 : -1)
                    + $signed($urandom_range(4)) - 2);
        else
            s = 16'($urandom());
        if ($urandom_range(3) == 0)
            f = 16'($signed($urandom_range(16000)) - 8000);
        send_sample(s, f);
    endtask

    initial
    begin
        logic [15:0] thr;
        sb = new();
        errors = 0;
        snd_idle = 22;
        rcv_idle = 45;
        hold_req = 0;
        hold_left = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rls_pkg::CFG_SLIP_THR;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, threshold edges and field extremes
        send_sample(16'd0, 16'd0);
        send_sample(16'd409, 16'd1000);
        send_sample(16'd410, 16'h7fff);
        send_sample(-16'sd410, 16'h8000);
        send_sample(16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h8000, 16'h7fff);
        send_sample(16'hffff, 16'hffff);
        drain();
        // zero threshold with zero lambda: a zero slip leaves the denominator too small
        write_reg(rls_pkg::CFG_SLIP_THR, 16'd0);
        write_reg(rls_pkg::CFG_LAMBDA, 16'd0);
        send_sample(16'd0, 16'd5000);
        send_sample(16'd1, 16'h8000);
        send_sample(16'd2000, 16'd1500);
        drain();
        write_reg(rls_pkg::CFG_LAMBDA, 16'hffff);
        write_reg(rls_pkg::CFG_FR_INIT, 16'hffff);
        write_reg(CFG_SPARE, 16'h1234);
        send_sample(16'd3000, 16'h7fff);
        send_sample(16'hd000, 16'h8000);
        drain();
        write_reg(rls_pkg::CFG_SLIP_THR, 16'hffff);
        write_reg(rls_pkg::CFG_FR_INIT, 16'd0);
        send_sample(16'h7fff, 16'd100);
        send_sample(16'h8000, 16'd100);
        drain();
        write_reg(rls_pkg::CFG_SLIP_THR, 16'd410);
        write_reg(rls_pkg::CFG_LAMBDA, 16'd29491);
        write_reg(rls_pkg::CFG_FR_INIT, 16'd12288);
        send_sample(16'd4000, 16'd4000);
        send_sample(16'd20000, 16'h8000);
        drain();
        write_reg(rls_pkg::CFG_LAMBDA, 16'd32768);
        write_reg(rls_pkg::CFG_FR_INIT, 16'd819);
        send_sample(16'd8192, 16'd8192);
        send_sample(16'd8192, 16'd8192);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            snd_idle = (phase == 0) ? 22 : (phase == 1 ? 45 : 0);
            rcv_idle = (phase == 0) ? 45 : (phase == 1 ? 22 : 0);
            for (int seg = 0; seg < 3; seg++)
            begin
                thr = ($urandom_range(4) == 0) ? 16'($urandom()) : 16'($urandom_range(1500));
                write_reg(rls_pkg::CFG_SLIP_THR, thr);
                write_reg(rls_pkg::CFG_LAMBDA, ($urandom_range(5) == 0) ? 16'($urandom())
                                      : 16'($urandom_range(32768, 29491)));
                write_reg(rls_pkg::CFG_FR_INIT, ($urandom_range(5) == 0) ? 16'($urandom())
                                       : 16'($urandom_range(12288, 819)));
                if ($urandom_range(1))
                    write_reg(CFG_SPARE, 16'($urandom()));
                for (int n = 0; n < 120; n++)
                begin
                    if (phase == 1 && seg == 1 && n == 10)
                        hold_req = 1;
                    if (phase == 1 && seg == 1 && n == 14)
                        hold_req = 0;
                    random_sample();
                end
                drain();
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0 && sb.pending.size() == 0)
            $display("** rls_friction_estimator: PASSED **");
        else
            $display("** rls_friction_estimator: FAILED **");
        $finish;
    end

    initial
    begin
        #(12 * 8_000_000);
        $display("** rls_friction_estimator: FAILED **");
        $finish;
    end

endmodule

// File: rls_friction_estimator.f
+incdir+rtl
rtl/rls_pkg.sv
rtl/rls_mdu.sv
rtl/rls_friction_estimator.sv
tb/rls_friction_estimator_test.sv
